// ----- rtl/esd_pkg.sv -----
// ----------------------------------------------------------------------------
// esd_pkg: escaped identifier string decoder shared definitions
// Phase codes, character constants, result beat type and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

	localparam int unsigned MAX_ID_BYTES = 64;

	localparam logic [2:0] PH_SKIP = 3'd0;
	localparam logic [2:0] PH_COPY = 3'd1;
	localparam logic [2:0] PH_ESC  = 3'd2;
	localparam logic [2:0] PH_OCT  = 3'd3;
	localparam logic [2:0] PH_HEX  = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_LEN  = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] id_byte;
		logic [7:0] final_length;
		logic       last;
	} res_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {["0":"9"]})
			r = {1'b1, 4'(c - 8'h30)};
		else if (c inside {["a":"f"]})
			r = {1'b1, 4'(c - 8'h57)};
		else if (c inside {["A":"F"]})
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic logic [2:0] ph_after(input logic [7:0] cnt);
		return (cnt >= 8'(MAX_ID_BYTES)) ? PH_DONE : PH_COPY;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/esd_step.sv -----
// ----------------------------------------------------------------------------
// esd_step: per-character decode step
// Works out the next decoder state and up to two result beats for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_step import esd_pkg::*; (
	input  wire logic [2:0] phase,
	input  wire logic [8:0] esc_val,
	input  wire logic [1:0] digit_cnt,
	input  wire logic [7:0] byte_cnt,
	input  wire logic [7:0] char_code,
	input  wire logic       end_marker,
	output logic      [2:0] phase_nxt,
	output logic      [8:0] esc_val_nxt,
	output logic      [1:0] digit_cnt_nxt,
	output logic      [7:0] byte_cnt_nxt,
	output logic      [1:0] n_res,
	output res_t            res0,
	output res_t            res1
);

	logic [7:0] cnt1;
	logic [7:0] cnt2;
	logic [4:0] hv;
	logic       is_oct;
	logic       is_dig;
	logic [8:0] dig_val;
	logic [1:0] dig_cnt;
	logic       run_full;

	assign cnt1   = byte_cnt + 8'd1;
	assign cnt2   = byte_cnt + 8'd2;
	assign hv     = hex_val(char_code);
	assign is_oct = char_code inside {["0":"7"]};
	assign is_dig = (phase == PH_OCT) ? is_oct : hv[4];
	assign dig_val = (phase == PH_OCT) ? {esc_val[5:0], char_code[2:0]}
	                                   : {esc_val[4:0], hv[3:0]};
	assign dig_cnt = digit_cnt + 2'd1;
	assign run_full = (phase == PH_OCT) ? (dig_cnt == 2'd3) : (dig_cnt >= 2'd2);

	always_comb begin
		phase_nxt     = phase;
		esc_val_nxt   = esc_val;
		digit_cnt_nxt = digit_cnt;
		byte_cnt_nxt  = byte_cnt;
		n_res         = 2'd0;
		res0          = '0;
		res1          = '0;

		if (end_marker) begin
			if (phase == PH_OCT || phase == PH_HEX) begin
				res0.kind    = KIND_BYTE;
				res0.id_byte = esc_val[7:0];
				res1.kind    = KIND_LEN;
				res1.final_length = cnt1;
				n_res        = 2'd2;
			end else begin
				res0.kind    = KIND_LEN;
				res0.final_length = byte_cnt;
				n_res        = 2'd1;
			end
			phase_nxt     = PH_SKIP;
			esc_val_nxt   = '0;
			digit_cnt_nxt = '0;
			byte_cnt_nxt  = '0;
		end else begin
			case (phase)
				PH_SKIP, PH_COPY: begin
					if (phase == PH_SKIP && (is_ws(char_code) || char_code == CH_QUOTE)) begin
						phase_nxt = PH_SKIP;
					end else if (char_code == CH_NUL || char_code == CH_QUOTE) begin
						phase_nxt = PH_DONE;
					end else if (char_code == CH_BSLASH) begin
						phase_nxt = PH_ESC;
					end else begin
						res0.id_byte = char_code;
						n_res        = 2'd1;
						byte_cnt_nxt = cnt1;
						phase_nxt    = ph_after(cnt1);
					end
				end
				PH_ESC: begin
					if (is_oct) begin
						esc_val_nxt   = {6'd0, char_code[2:0]};
						digit_cnt_nxt = 2'd1;
						phase_nxt     = PH_OCT;
					end else if (char_code == CH_X) begin
						esc_val_nxt   = '0;
						digit_cnt_nxt = '0;
						phase_nxt     = PH_HEX;
					end else if (char_code == CH_NUL) begin
						phase_nxt = PH_DONE;
					end else begin
						res0.id_byte = char_code;
						n_res        = 2'd1;
						byte_cnt_nxt = cnt1;
						phase_nxt    = ph_after(cnt1);
					end
				end
				PH_OCT, PH_HEX: begin
					if (is_dig) begin
						esc_val_nxt   = dig_val;
						digit_cnt_nxt = dig_cnt;
						if (run_full) begin
							res0.id_byte = dig_val[7:0];
							n_res        = 2'd1;
							byte_cnt_nxt = cnt1;
							phase_nxt    = ph_after(cnt1);
						end
					end else begin
						// close the run, then treat the ending character as plain text
						res0.id_byte = esc_val[7:0];
						n_res        = 2'd1;
						byte_cnt_nxt = cnt1;
						phase_nxt    = ph_after(cnt1);
						if (ph_after(cnt1) == PH_COPY) begin
							if (char_code == CH_NUL || char_code == CH_QUOTE) begin
								phase_nxt = PH_DONE;
							end else if (char_code == CH_BSLASH) begin
								phase_nxt = PH_ESC;
							end else begin
								res1.id_byte = char_code;
								n_res        = 2'd2;
								byte_cnt_nxt = cnt2;
								phase_nxt    = ph_after(cnt2);
							end
						end
					end
				end
				default: begin
					phase_nxt = PH_DONE;
				end
			endcase
		end

		res0.last = (n_res == 2'd1);
		res1.last = 1'b1;
	end

endmodule

`default_nettype wire

// ----- rtl/escaped_id_string_decoder.sv -----
// ----------------------------------------------------------------------------
// escaped_id_string_decoder: quoted identifier string decoder
// Skips leading blanks and quotes, copies characters and decodes octal, hex
// and literal backslash escapes; an end beat reports the decoded length.
// ----------------------------------------------------------------------------
// Usage:
//  Input stream: one character per beat on s_tdata, or an end beat with
//  s_tuser high (s_tdata then ignored). Output stream: one result per beat,
//  m_tuser low for a decoded byte (m_tdata[7:0]), high for the final length
//  (m_tdata[15:8]); m_tlast marks the last result caused by an input beat.
//  Path: a result is valid once its input beat has passed the input register
//  and the decode step has written it into the result queue.
//  Throughput: one input beat per cycle while the queue has room; the output
//  side moves one result per cycle, so beats giving two results (a run closed
//  by a plain character, or an end beat flushing a run) can fill the queue.
//  The input register hands an item to the decode step when the four-entry
//  result queue has room for two results.
//  Stall: with m_tready low the queue fills and s_tready drops once the
//  input register holds a waiting item; nothing is lost.
//  Reset: arst_n clears the queue, the input register and the decoder
//  state, which restarts in the leading-skip phase with a zero length.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_id_string_decoder import esd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tuser,   // [0] end_marker
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // [7:0] id_byte, [15:8] final_length
	output logic             m_tuser,   // [0] kind
	output logic             m_tlast    // last
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;

	logic [2:0] phase_q;
	logic [8:0] esc_val_q;
	logic [1:0] digit_cnt_q;
	logic [7:0] byte_cnt_q;

	logic [2:0] phase_nxt;
	logic [8:0] esc_val_nxt;
	logic [1:0] digit_cnt_nxt;
	logic [7:0] byte_cnt_nxt;
	logic [1:0] n_res;
	res_t       res0;
	res_t       res1;

	res_t       fifo_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] count_q;

	logic       fire;
	logic       pop;
	logic       s_acc;
	logic [1:0] n_push;
	res_t       head;

	assign fire     = valid_s1 && (count_q <= 3'd2);
	assign s_tready = !valid_s1 || fire;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = (count_q != 3'd0);
	assign pop      = m_tvalid && m_tready;
	assign n_push   = fire ? n_res : 2'd0;

	esd_step u_step (
		.phase         (phase_q),
		.esc_val       (esc_val_q),
		.digit_cnt     (digit_cnt_q),
		.byte_cnt      (byte_cnt_q),
		.char_code     (char_s1),
		.end_marker    (end_s1),
		.phase_nxt     (phase_nxt),
		.esc_val_nxt   (esc_val_nxt),
		.digit_cnt_nxt (digit_cnt_nxt),
		.byte_cnt_nxt  (byte_cnt_nxt),
		.n_res         (n_res),
		.res0          (res0),
		.res1          (res1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			char_s1 <= s_tdata;
			end_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			esc_val_q   <= '0;
			digit_cnt_q <= '0;
			byte_cnt_q  <= '0;
		end else if (fire) begin
			phase_q     <= phase_nxt;
			esc_val_q   <= esc_val_nxt;
			digit_cnt_q <= digit_cnt_nxt;
			byte_cnt_q  <= byte_cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + n_push;
			rptr_q  <= rptr_q + {1'b0, pop};
			count_q <= count_q + {1'b0, n_push} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			fifo_q[wptr_q] <= res0;
		if (n_push == 2'd2)
			fifo_q[wptr_q + 2'd1] <= res1;
	end

	assign head    = fifo_q[rptr_q];
	assign m_tdata = {head.final_length, head.id_byte};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue over capacity");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q <= 8'(MAX_ID_BYTES))
		else $error("decoded length passed the limit");

	a_skip_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (byte_cnt_q == 8'd0))
		else $error("bytes counted while still skipping leading text");

	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_s1) |=> (phase_q == PH_SKIP && byte_cnt_q == 8'd0))
		else $error("decoder not restarted after end beat");

endmodule

`default_nettype wire
